// ----- design/aqs_pkg.sv -----
// ----------------------------------------------------------------------------
// aqs_pkg: shared types and constants for the air quality score block
// breakpoint tables, per-segment interpolation constants and band codes
// ----------------------------------------------------------------------------
package aqs_pkg;

  localparam int BP_N      = 6;             // breakpoints per table
  localparam int SEG_N     = BP_N - 1;      // interpolated segments
  localparam int VAL_W     = 16;            // reading width
  localparam int SCORE_W   = 7;             // subscore / score width
  localparam int BAND_W    = 3;
  localparam int SEG_W     = 3;             // segment code 0..BP_N
  localparam int IDX_W     = 3;             // segment index 0..SEG_N-1
  localparam int X_W       = 10;            // offset into a segment, max 1000
  localparam int SLOPE_W   = 6;             // twice the score drop, max 50
  localparam int NUM_W     = 17;            // doubled, rounded numerator
  localparam int RECIP_SH  = 28;
  localparam int RECIP_W   = 22;
  localparam int PROD_W    = NUM_W + RECIP_W;

  localparam int unsigned RECIP_ONE = 2 ** RECIP_SH;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd100;
  localparam logic [SCORE_W-1:0] SCORE_MIN = 7'd0;

  // band thresholds and codes
  localparam logic [SCORE_W-1:0] TH_EXCELLENT = 7'd90;
  localparam logic [SCORE_W-1:0] TH_GOOD      = 7'd75;
  localparam logic [SCORE_W-1:0] TH_MODERATE  = 7'd50;
  localparam logic [SCORE_W-1:0] TH_POOR      = 7'd25;

  localparam logic [BAND_W-1:0] BAND_EXCELLENT   = 3'd0;
  localparam logic [BAND_W-1:0] BAND_GOOD        = 3'd1;
  localparam logic [BAND_W-1:0] BAND_MODERATE    = 3'd2;
  localparam logic [BAND_W-1:0] BAND_POOR        = 3'd3;
  localparam logic [BAND_W-1:0] BAND_BAD         = 3'd4;
  localparam logic [BAND_W-1:0] BAND_UNAVAILABLE = 3'd5;

  // breakpoint tables, concentration -> score
  localparam int unsigned CO2_PT   [BP_N] = '{600, 800, 1000, 1400, 2000, 3000};
  localparam int unsigned PM_PT    [BP_N] = '{50, 100, 150, 250, 500, 1000};
  localparam int unsigned SCORE_PT [BP_N] = '{100, 90, 75, 50, 25, 0};

  // reciprocals of twice the segment width, ceil(2^28 / d), exact for 17-bit numerators
  localparam int unsigned CO2_RECIP [SEG_N] = '{
    (RECIP_ONE + 399) / 400, (RECIP_ONE + 399) / 400, (RECIP_ONE + 799) / 800,
    (RECIP_ONE + 1199) / 1200, (RECIP_ONE + 1999) / 2000};
  localparam int unsigned PM_RECIP [SEG_N] = '{
    (RECIP_ONE + 99) / 100, (RECIP_ONE + 99) / 100, (RECIP_ONE + 199) / 200,
    (RECIP_ONE + 499) / 500, (RECIP_ONE + 999) / 1000};

  // constants one lane needs for its reading
  typedef struct packed {
    logic [BP_N-1:0][VAL_W-1:0]     pts;
    logic [SEG_N-1:0][NUM_W-1:0]    base;    // (2*score_lo + 1) * width
    logic [SEG_N-1:0][SLOPE_W-1:0]  slope2;  // 2 * (score_lo - score_hi)
    logic [SEG_N-1:0][RECIP_W-1:0]  recip;
  } aqs_tab_t;

  // per-item flags that ride alongside the lanes
  typedef struct packed {
    logic missing;
    logic fault;
  } aqs_flags_t;

  function automatic aqs_tab_t lane_tab(input logic pm);
    aqs_tab_t    t;
    int unsigned lo;
    int unsigned hi;
    t = '0;
    for (int i = 0; i < BP_N; i++) begin
      t.pts[i] = VAL_W'(pm ? PM_PT[i] : CO2_PT[i]);
    end
    for (int k = 0; k < SEG_N; k++) begin
      lo = pm ? PM_PT[k] : CO2_PT[k];
      hi = pm ? PM_PT[k+1] : CO2_PT[k+1];
      t.base[k]   = NUM_W'((2 * SCORE_PT[k] + 1) * (hi - lo));
      t.slope2[k] = SLOPE_W'(2 * (SCORE_PT[k] - SCORE_PT[k+1]));
      t.recip[k]  = RECIP_W'(pm ? PM_RECIP[k] : CO2_RECIP[k]);
    end
    return t;
  endfunction

  localparam aqs_tab_t CO2_TAB = lane_tab(1'b0);
  localparam aqs_tab_t PM_TAB  = lane_tab(1'b1);

endpackage

// ----- design/aqs_lane.sv -----
// ----------------------------------------------------------------------------
// aqs_lane: piecewise-linear subscore lane
// three-stage pipeline: segment search, rounded numerator, reciprocal divide
// ----------------------------------------------------------------------------
module aqs_lane
  import aqs_pkg::*;
(
  input  logic               clk,
  input  aqs_tab_t           tab,
  input  logic [VAL_W-1:0]   value,
  output logic [SCORE_W-1:0] subscore
);

  logic [SEG_W-1:0]   seg;
  logic [IDX_W-1:0]   idx;
  logic [VAL_W-1:0]   diff;

  logic               sat_hi_a, sat_lo_a;
  logic [IDX_W-1:0]   idx_a;
  logic [X_W-1:0]     x_a;

  logic               sat_hi_b, sat_lo_b;
  logic [IDX_W-1:0]   idx_b;
  logic [NUM_W-1:0]   num_b;

  logic [PROD_W-1:0]  prod;

  // segment code: number of breakpoints strictly below the reading
  always_comb begin
    seg = '0;
    for (int i = 0; i < BP_N; i++) begin
      if (value > tab.pts[i]) begin
        seg = SEG_W'(i + 1);
      end
    end
    if (seg == '0) begin
      idx = '0;
    end else if (seg == SEG_W'(BP_N)) begin
      idx = IDX_W'(SEG_N - 1);
    end else begin
      idx = IDX_W'(seg - SEG_W'(1));
    end
    diff = value - tab.pts[idx];
  end

  always_ff @(posedge clk) begin
    sat_hi_a <= (seg == '0);
    sat_lo_a <= (seg == SEG_W'(BP_N));
    idx_a    <= idx;
    x_a      <= diff[X_W-1:0];
  end

  // 2*num + width, never below the width inside a segment
  always_ff @(posedge clk) begin
    sat_hi_b <= sat_hi_a;
    sat_lo_b <= sat_lo_a;
    idx_b    <= idx_a;
    num_b    <= tab.base[idx_a] - (NUM_W'(tab.slope2[idx_a]) * NUM_W'(x_a));
  end

  assign prod = PROD_W'(num_b) * PROD_W'(tab.recip[idx_b]);

  always_ff @(posedge clk) begin
    priority if (sat_hi_b) begin
      subscore <= SCORE_MAX;
    end else if (sat_lo_b) begin
      subscore <= SCORE_MIN;
    end else begin
      subscore <= prod[RECIP_SH +: SCORE_W];
    end
  end

endmodule

// ----- design/aqs_merge.sv -----
// ----------------------------------------------------------------------------
// aqs_merge: combines the lane subscores
// minimum, missing-pm override, band classification and fault override, registered
// ----------------------------------------------------------------------------
module aqs_merge
  import aqs_pkg::*;
(
  input  logic               clk,
  input  aqs_flags_t         flags,
  input  logic [SCORE_W-1:0] co2_sub,
  input  logic [SCORE_W-1:0] pm_sub,
  output logic [SCORE_W-1:0] air_score,
  output logic [BAND_W-1:0]  score_band,
  output logic [SCORE_W-1:0] co2_subscore,
  output logic [SCORE_W-1:0] pm25_subscore
);

  logic [SCORE_W-1:0] pm_eff;
  logic [SCORE_W-1:0] low;
  logic [BAND_W-1:0]  band;

  always_comb begin
    pm_eff = flags.missing ? SCORE_MIN : pm_sub;
    low    = (co2_sub < pm_eff) ? co2_sub : pm_eff;
    priority if (low >= TH_EXCELLENT) begin
      band = BAND_EXCELLENT;
    end else if (low >= TH_GOOD) begin
      band = BAND_GOOD;
    end else if (low >= TH_MODERATE) begin
      band = BAND_MODERATE;
    end else if (low >= TH_POOR) begin
      band = BAND_POOR;
    end else begin
      band = BAND_BAD;
    end
  end

  always_ff @(posedge clk) begin
    co2_subscore  <= co2_sub;
    pm25_subscore <= pm_eff;
    if (flags.fault) begin
      air_score  <= SCORE_MIN;
      score_band <= BAND_UNAVAILABLE;
    end else begin
      air_score  <= low;
      score_band <= band;
    end
  end

endmodule

// ----- design/air_quality_score.sv -----
// ----------------------------------------------------------------------------
// air_quality_score: combined indoor air quality score
// two interpolation lanes (co2, pm2.5) run side by side, a merge stage takes
// the smaller subscore, classifies it into a band and applies the fault flag
// ----------------------------------------------------------------------------
// done rises with the result once the beat has passed the 3 lane stages and the merge
// throughput: one beat per cycle, busy is never raised outside reset
// the pipeline depth is set by the lane: segment search, numerator, divide
// reset: synchronous, clears the valid pipeline; busy follows rst
// results are presented for one cycle with done; the receiver cannot stall
// ----------------------------------------------------------------------------
module air_quality_score
  import aqs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [VAL_W-1:0]   co2_ppm,
  input  logic [VAL_W-1:0]   pm25_tenths,
  input  logic               pm25_missing,
  input  logic               sensor_fault,
  output logic               done,
  output logic [SCORE_W-1:0] air_score,
  output logic [BAND_W-1:0]  score_band,
  output logic [SCORE_W-1:0] co2_subscore,
  output logic [SCORE_W-1:0] pm25_subscore
);

  localparam int LANE_LAT = 3;

  logic                  accept;
  logic [LANE_LAT-1:0]   vld;             // one bit per lane stage
  aqs_flags_t            flag_pipe [LANE_LAT];
  logic [SCORE_W-1:0]    co2_sub;
  logic [SCORE_W-1:0]    pm_sub;

  // no backpressure: only reset holds off a beat
  assign busy   = rst;
  assign accept = start && !busy;

  // valid travels beside the lanes, done marks the merged result
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[LANE_LAT-2:0], accept};
      done <= vld[LANE_LAT-1];
    end
  end

  // flags are only needed by the merge, delay them to match the lanes
  always_ff @(posedge clk) begin
    flag_pipe[0] <= '{missing: pm25_missing, fault: sensor_fault};
    for (int i = 1; i < LANE_LAT; i++) begin
      flag_pipe[i] <= flag_pipe[i-1];
    end
  end

  // co2 lane
  aqs_lane u_lane_co2 (
    .clk      (clk),
    .tab      (CO2_TAB),
    .value    (co2_ppm),
    .subscore (co2_sub)
  );

  // pm2.5 lane, computed even when the reading is missing
  aqs_lane u_lane_pm (
    .clk      (clk),
    .tab      (PM_TAB),
    .value    (pm25_tenths),
    .subscore (pm_sub)
  );

  // merge: min, band, fault override
  aqs_merge u_merge (
    .clk           (clk),
    .flags         (flag_pipe[LANE_LAT-1]),
    .co2_sub       (co2_sub),
    .pm_sub        (pm_sub),
    .air_score     (air_score),
    .score_band    (score_band),
    .co2_subscore  (co2_subscore),
    .pm25_subscore (pm25_subscore)
  );

`ifndef ASSERT_OFF
  // every accepted beat comes out with done, after the lane stages and the merge register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("result strobe missing after accepted beat");

  // an unavailable band always carries a zero score
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (done && score_band == BAND_UNAVAILABLE) |-> (air_score == SCORE_MIN))
    else $error("unavailable band with nonzero score");

  // the combined score never exceeds either subscore
  a_min: assert property (@(posedge clk) disable iff (rst)
    done |-> (air_score <= co2_subscore && air_score <= pm25_subscore))
    else $error("score above a subscore");

  // subscores stay within range
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (co2_subscore <= SCORE_MAX && pm25_subscore <= SCORE_MAX))
    else $error("subscore out of range");
`endif

endmodule
